/* rtl/root_mean_square_error_unit_macros.svh */
// assertion macros for the rms error unit checker
`ifndef ROOT_MEAN_SQUARE_ERROR_UNIT_MACROS_SVH
`define ROOT_MEAN_SQUARE_ERROR_UNIT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define RMSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define RMSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rmse_pkg.sv */
// shared widths, limits and status codes of the rms error unit
`default_nettype none

package rmse_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int ACC_W      = 64;
  localparam int COUNT_W    = 15;
  localparam int ROOT_W     = ACC_W / 2;
  localparam int RMSE_W     = 25;
  localparam int STATUS_W   = 2;

  localparam int SQ_STEPS   = SAMPLE_W;
  localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
  localparam int DIV_STEPS  = ACC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int ROOT_STEPS = ROOT_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(16384);
  localparam logic [COUNT_W-1:0] MIN_SAMPLES = COUNT_W'(2);

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

/* rtl/rmse_sq.sv */
// bit-serial squarer, one multiplier bit per cycle
`default_nettype none

module rmse_sq
  import rmse_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [SAMPLE_W-1:0] mag_i,
  output logic                     done_o,
  output logic [SQ_W-1:0]          prod_o
);

  logic                run_q;
  logic                done_q;
  logic [SQ_CNT_W-1:0] cnt_q;
  logic [SAMPLE_W-1:0] mag_q;
  logic [SQ_W-1:0]     prod_q, prod_d;
  logic [SAMPLE_W:0]   psum;

  always_comb begin
    psum   = {1'b0, prod_q[SQ_W-1:SAMPLE_W]} +
             (prod_q[0] ? {1'b0, mag_q} : '0);
    prod_d = {psum, prod_q[SAMPLE_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= mag_i;
      prod_q <= {{SAMPLE_W{1'b0}}, mag_i};
    end else if (run_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* rtl/rmse_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module rmse_div
  import rmse_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [ACC_W-1:0]   dividend_i,
  input  wire logic [COUNT_W-1:0] divisor_i,
  output logic                    done_o,
  output logic [ACC_W-1:0]        quot_o
);

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0]     quot_q;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [COUNT_W-1:0]   dvs_q;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     diff;
  logic                 ge;

  always_comb begin
    trial = {rem_q, quot_q[ACC_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (run_q) begin
      quot_q <= {quot_q[ACC_W-2:0], ge};
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* rtl/rmse_sqrt.sv */
// digit-by-digit integer square root, one root bit per cycle
`default_nettype none

module rmse_sqrt
  import rmse_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ACC_W-1:0] radicand_i,
  output logic                  done_o,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CUR_W = REM_W + 2;

  logic                  run_q;
  logic                  done_q;
  logic [ROOT_CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0]      x_q;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q;
  logic [CUR_W-1:0]      cur;
  logic [CUR_W-1:0]      trial;
  logic [CUR_W-1:0]      diff;
  logic                  ge;

  always_comb begin
    cur   = {rem_q, x_q[ACC_W-1:ACC_W-2]};
    trial = {2'b00, root_q, 2'b01};
    diff  = cur - trial;
    ge    = (cur >= trial);
    rem_d = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      x_q    <= {x_q[ACC_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* rtl/root_mean_square_error_unit.sv */
// top level of the rms error unit: run state, control and output register
//
//  channel   direction  transaction contents
//  s_axis    in         sample_a, sample_b in tdata; last_sample in tlast
//  m_axis    out        rmse_value, sample_count in tdata; status in tuser
//  cfg       in         use_sample_divisor, one write per enabled cycle
//
// a pair is timed by the bit-serial squarer (24 steps); no new pair is taken until it is squared
// a last pair with a valid run then passes through the 64-step divider and the 32-step root
// a finished result waits in the output register while the next pair is taken
// a full output register with another result pending holds the input side
// reset clears the run state and the output valid flag at once
`default_nettype none

module root_mean_square_error_unit
  import rmse_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wen_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // sample_a [23:0], sample_b [47:24]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // rmse_value [24:0], sample_count [39:25]
  output logic [1:0]       m_axis_tuser    // status [1:0]
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [ACC_W-1:0]    sum_q, sum_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                ovf_q, ovf_d;
  logic                last_q, last_d;
  logic                use_div_q;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [COUNT_W-1:0]  res_count_q, res_count_d;
  logic [RMSE_W-1:0]   res_value_q, res_value_d;
  logic                m_valid_q;
  logic [RMSE_W-1:0]   m_value_q;
  logic [STATUS_W-1:0] m_status_q;
  logic [COUNT_W-1:0]  m_count_q;

  logic                in_acc;
  logic                out_load;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]   diff_abs;
  logic [SAMPLE_W-1:0] mag;
  logic [ACC_W:0]      acc_sum;
  logic [ACC_W-1:0]    sum_new;
  logic                ovf_new;
  logic [COUNT_W-1:0]  divisor;

  logic                sq_start, sq_done;
  logic [SQ_W-1:0]     sq_prod;
  logic                div_start, div_done;
  logic [ACC_W-1:0]    div_quot;
  logic                root_start, root_done;
  logic [ROOT_W-1:0]   root_val;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    diff     = $signed({s_axis_tdata[SAMPLE_W-1], s_axis_tdata[SAMPLE_W-1:0]}) -
               $signed({s_axis_tdata[2*SAMPLE_W-1], s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]});
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    mag      = diff_abs[SAMPLE_W-1:0];
    acc_sum  = {1'b0, sum_q} + {{(ACC_W + 1 - SQ_W){1'b0}}, sq_prod};
    sum_new  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    ovf_new  = ovf_q | acc_sum[ACC_W];
    divisor  = use_div_q ? count_q - 1'b1 : count_q;
  end

  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    last_d       = last_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_value_d  = res_value_q;
    sq_start     = 1'b0;
    div_start    = 1'b0;
    root_start   = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sq_start = 1'b1;
          last_d   = s_axis_tlast;
          if (count_q >= MAX_SAMPLES) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sq_done) begin
          sum_d   = sum_new;
          ovf_d   = ovf_new;
          state_d = ST_IDLE;
          if (last_q) begin
            res_count_d = count_q;
            res_value_d = '0;
            sum_d       = '0;
            count_d     = '0;
            ovf_d       = 1'b0;
            if (ovf_new) begin
              res_status_d = STATUS_OVERFLOW;
              state_d      = ST_HOLD;
            end else if (count_q < MIN_SAMPLES) begin
              res_status_d = STATUS_TOO_FEW;
              state_d      = ST_HOLD;
            end else begin
              res_status_d = STATUS_OK;
              div_start    = 1'b1;
              state_d      = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          root_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          res_value_d = (root_val[ROOT_W-1:RMSE_W] != '0) ? '1 : root_val[RMSE_W-1:0];
          state_d     = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sum_q     <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      use_div_q <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      if (cfg_wen_i) begin
        use_div_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      m_value_q  <= res_value_q;
      m_status_q <= res_status_q;
      m_count_q  <= res_count_q;
    end
  end

  rmse_sq u_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .mag_i  (mag),
    .done_o (sq_done),
    .prod_o (sq_prod)
  );

  rmse_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_new),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  rmse_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (root_start),
    .radicand_i(div_quot),
    .done_o    (root_done),
    .root_o    (root_val)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_count_q, m_value_q};
  assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire

/* rtl/rmse_checker.sv */
// port-level checker for the rms error unit and its bind
`default_nettype none

`include "root_mean_square_error_unit_macros.svh"

module rmse_checker
  import rmse_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_wen_i,
  input wire logic        cfg_wdata_i,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [47:0] s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  logic [COUNT_W-1:0] out_count;
  logic               in_xfer;
  logic               cfg_seen;

  assign out_count = m_axis_tdata[39:25];
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign cfg_seen  = cfg_wen_i && cfg_wdata_i && s_axis_tlast && (s_axis_tdata != '0);

  `RMSE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  `RMSE_ASSERT_NXT(a_one_pair, clk_i, rst_ni, in_xfer || cfg_seen && in_xfer, !s_axis_tready, "second pair taken while squaring")

  `RMSE_ASSERT_IMP(a_err_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != STATUS_OK), m_axis_tdata[24:0] == '0, "nonzero value with error status")

  `RMSE_ASSERT_IMP(a_too_few, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == STATUS_TOO_FEW), out_count < MIN_SAMPLES, "too few status with enough pairs")

  `RMSE_ASSERT_IMP(a_count_max, clk_i, rst_ni, m_axis_tvalid, out_count <= MAX_SAMPLES, "pair count past bound")

endmodule

bind root_mean_square_error_unit rmse_checker u_rmse_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// testbench for the rms error unit: directed table, random runs and a self-checking predictor
`timescale 1ns / 100ps

module tb;
  import rmse_pkg::*;

  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_CYCLES   = 3000;
  localparam int PHASE_ITEMS   = 160;
  localparam int RUN_LIMIT     = 16384;

  typedef enum logic [0:0] {ROW_PAIR, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [RMSE_W-1:0]   rmse;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } rmse_result_t;

  typedef struct {
    row_kind_e     kind;
    logic [23:0]   a;
    logic [23:0]   b;
    bit            last;
    bit            cfg_value;
    bit            typed;
    rmse_result_t  want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wen_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  root_mean_square_error_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wen_i     (cfg_wen_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state
  logic [63:0]  run_sum;
  int           run_pairs;
  bit           run_overflow;
  bit           divide_by_n_minus_1;

  rmse_result_t pending_rmse[$];
  stim_row_t    directed_rows[$];
  int           mismatch_count;
  int           accepted_pairs;
  int unsigned  sender_idle_pct;
  int unsigned  receiver_idle_pct;
  int           hold_requests;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = x;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic fold_pair(input logic [23:0] a, input logic [23:0] b, input bit last,
                           output bit produced, output rmse_result_t res);
    longint          sa;
    longint          sb;
    longint          diff;
    logic [63:0]     sq;
    logic [63:0]     root;
    logic [63:0]     divisor;
    sa   = longint'($signed(a));
    sb   = longint'($signed(b));
    diff = sa - sb;
    if (diff < 0) diff = -diff;
    sq = 64'(diff) * 64'(diff);
    if (run_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
      run_sum      = 64'hFFFF_FFFF_FFFF_FFFF;
      run_overflow = 1'b1;
    end else begin
      run_sum = run_sum + sq;
    end
    if (run_pairs >= RUN_LIMIT) begin
      run_pairs    = RUN_LIMIT;
      run_overflow = 1'b1;
    end else begin
      run_pairs++;
    end
    produced = last;
    res      = '0;
    if (last) begin
      res.count = COUNT_W'(run_pairs);
      if (run_overflow) begin
        res.status = STATUS_OVERFLOW;
      end else if (run_pairs < 2) begin
        res.status = STATUS_TOO_FEW;
      end else begin
        divisor = divide_by_n_minus_1 ? 64'(run_pairs - 1) : 64'(run_pairs);
        root    = floor_root(run_sum / divisor);
        if (root > 64'h1FF_FFFF) root = 64'h1FF_FFFF;
        res.rmse   = root[RMSE_W-1:0];
        res.status = STATUS_OK;
      end
      run_sum      = '0;
      run_pairs    = 0;
      run_overflow = 1'b0;
    end
  endtask

  task automatic send_pair(input logic [23:0] a, input logic [23:0] b, input bit last,
                           input bit typed, input rmse_result_t typed_res);
    bit           produced;
    rmse_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    accepted_pairs++;
    fold_pair(a, b, last, produced, res);
    if (produced) pending_rmse.insert(pending_rmse.size(), typed ? typed_res : res);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_rmse.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_divisor(input bit value);
    @(negedge clk_i);
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_wen_i   <= 1'b0;
    divide_by_n_minus_1 = value;
  endtask

  function automatic logic [23:0] pick_sample();
    logic [23:0] v;
    case ($urandom_range(7))
      4: begin
        case ($urandom_range(3))
          0: v = 24'h7F_FFFF;
          1: v = 24'h80_0000;
          2: v = 24'h00_0000;
          default: v = 24'hFF_FFFF;
        endcase
      end
      5: v = 24'($urandom_range(8191)) - 24'd4096;
      6: v = 24'($urandom_range(255)) << $urandom_range(16);
      default: v = 24'($urandom);
    endcase
    return v;
  endfunction

  function automatic int pick_run_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 1;
    if (r < 30) return 2;
    if (r < 90) return $urandom_range(8, 3);
    return $urandom_range(40, 9);
  endfunction

  task automatic send_run(input int len);
    logic [23:0] a;
    logic [23:0] b;
    for (int i = 0; i < len; i++) begin
      a = pick_sample();
      b = ($urandom_range(9) == 0) ? a : pick_sample();
      send_pair(a, b, i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic add_row(input row_kind_e kind, input logic [23:0] a, input logic [23:0] b,
                         input bit last, input bit typed, input logic [RMSE_W-1:0] rmse,
                         input logic [STATUS_W-1:0] status, input int count);
    stim_row_t row;
    row.kind        = kind;
    row.a           = a;
    row.b           = b;
    row.last        = last;
    row.cfg_value   = a[0];
    row.typed       = typed;
    row.want.rmse   = rmse;
    row.want.status = status;
    row.want.count  = COUNT_W'(count);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      int hold_left;
      int hold_served;
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    rmse_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_rmse.size() == 0) begin
        $error("unexpected result transaction rmse_value %0d status %0d sample_count %0d",
               m_axis_tdata[24:0], m_axis_tuser, m_axis_tdata[39:25]);
        mismatch_count++;
      end else begin
        want = pending_rmse.pop_front();
        if (m_axis_tdata[24:0] !== want.rmse) begin
          $error("rmse_value expected %0d actual %0d", want.rmse, m_axis_tdata[24:0]);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status expected %0d actual %0d", want.status, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[39:25] !== want.count) begin
          $error("sample_count expected %0d actual %0d", want.count, m_axis_tdata[39:25]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int phase_start;
    rst_ni              = 1'b0;
    cfg_wen_i           = 1'b0;
    cfg_wdata_i         = 1'b0;
    s_axis_tvalid       = 1'b0;
    s_axis_tdata        = '0;
    s_axis_tlast        = 1'b0;
    run_sum             = '0;
    run_pairs           = 0;
    run_overflow        = 1'b0;
    divide_by_n_minus_1 = 1'b1;
    mismatch_count      = 0;
    accepted_pairs      = 0;
    hold_requests       = 0;
    sender_idle_pct     = 31;
    receiver_idle_pct   = 77;

    // reset divisor is count minus one
    add_row(ROW_PAIR, 24'h00_0000, 24'h00_0000, 1'b1, 1'b1, '0, STATUS_TOO_FEW, 1);
    add_row(ROW_PAIR, 24'h7F_FFFF, 24'h80_0000, 1'b1, 1'b1, '0, STATUS_TOO_FEW, 1);
    add_row(ROW_PAIR, 24'h7F_FFFF, 24'h80_0000, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h80_0000, 24'h7F_FFFF, 1'b1, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h12_3456, 24'h12_3456, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h80_0000, 24'h80_0000, 1'b1, 1'b1, '0, STATUS_OK, 2);
    add_row(ROW_PAIR, 24'h00_0001, 24'h00_0000, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h00_0000, 24'h00_0001, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'hFF_FFFF, 24'h00_0000, 1'b1, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_CFG,  24'h00_0000, 24'h00_0000, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h00_0000, 24'h7F_FFFF, 1'b1, 1'b1, '0, STATUS_TOO_FEW, 1);
    add_row(ROW_PAIR, 24'h7F_FFFF, 24'h80_0000, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h80_0000, 24'h7F_FFFF, 1'b1, 1'b1, 25'hFF_FFFF, STATUS_OK, 2);
    add_row(ROW_PAIR, 24'h40_0000, 24'hC0_0000, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h00_0000, 24'h00_0000, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h00_0ABC, 24'hFF_F123, 1'b1, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_CFG,  24'h00_0001, 24'h00_0000, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h7F_FFFF, 24'h7F_FFFF, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h80_0000, 24'h80_0000, 1'b1, 1'b1, '0, STATUS_OK, 2);
    add_row(ROW_PAIR, 24'h55_5555, 24'hAA_AAAA, 1'b1, 1'b1, '0, STATUS_TOO_FEW, 1);
    add_row(ROW_PAIR, 24'hAA_AAAA, 24'h55_5555, 1'b0, 1'b0, '0, STATUS_OK, 0);
    add_row(ROW_PAIR, 24'h55_5555, 24'hAA_AAAA, 1'b1, 1'b0, '0, STATUS_OK, 0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_divisor(directed_rows[i].cfg_value);
      end else begin
        send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          sender_idle_pct   = 31;
          receiver_idle_pct = 77;
          write_divisor(1'b0);
        end
        1: begin
          sender_idle_pct   = 77;
          receiver_idle_pct = 31;
          write_divisor(1'b1);
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          write_divisor(1'($urandom_range(1)));
          // receiver stalls while short runs pile up behind the output register
          hold_requests++;
          repeat (24) send_run($urandom_range(2, 1));
          settle();
        end
      endcase
      phase_start = accepted_pairs;
      while (accepted_pairs - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(5) == 0) begin
          settle();
          write_divisor(1'($urandom_range(1)));
        end
        send_run(pick_run_len());
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
